FILE: sv/wsvt_pkg.sv
// ----------------------------------------------------------------------------
// wsvt_pkg
// shared widths and constants of the wheel speed and vibration telemetry unit
// ----------------------------------------------------------------------------
package wsvt_pkg;

    localparam int unsigned NUM_W  = 52;
    localparam int unsigned DEN_W  = 5;
    localparam int unsigned ROOT_W = 26;
    localparam int unsigned MUL_W  = 26;

    localparam logic [17:0] INV_TWO_PI_Q20 = 18'd166886;
    localparam logic [22:0] SPEED_FLOOR    = 23'd3277;
    localparam logic [22:0] SPEED_MAX      = 23'd8388607;
    localparam logic [18:0] CIRC_RESET     = 19'd137953;
    localparam logic [15:0] TEMP_RESET     = 16'd2560;
    localparam logic [23:0] MEAN_MAX       = 24'hFFFFFF;
    localparam logic [51:0] SUM_MAX        = {52{1'b1}};
    localparam logic [22:0] RMS_MAX        = 23'd8388607;
    // ceil(2^27 / 5), exact floor division by 5 for numerators below 2^26
    localparam logic [25:0] RECIP_5        = 26'd26843546;

endpackage

FILE: sv/wheel_speed_vibration_telemetry_unit.sv
// ----------------------------------------------------------------------------
// wheel_speed_vibration_telemetry_unit
// per-sample wheel speed, filtered acceleration and windowed rms vibration
//
//   channel   dir   width  fields
//   s_axis    in    120    spin rate, accel axes, die temperature, flags
//   m_axis    out   88     speed, filtered accel, temperature, rms
//   cfg       in    19     tire circumference
//
// an item may pass through three speed multiplies, one reciprocal multiply each
// for the filter and the mean, and the 26-step square root; a frame item adds
// the 52-step divider, a second square root and the output state, plus any
// wait for the receiver
// s_tready is high only in the idle state; a frame waits in the output
// register and the next item is still taken while it waits
// reset is synchronous, active low, and clears all filter state
// ----------------------------------------------------------------------------
module wheel_speed_vibration_telemetry_unit #(
    parameter int FRAME_DIVISOR  = 10,
    parameter int SAMPLE_RATE_HZ = 100
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // spin_rate, spin_rate_valid, accel_x, accel_y, accel_z, accel_valid,
    // die_temperature, temperature_valid
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // speed, filtered_acceleration, temperature, vibration_rms
    output logic [87:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [18:0]  cfg_wr_data
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_SPD0   = 5'd1;
    localparam logic [4:0] ST_SPD1   = 5'd2;
    localparam logic [4:0] ST_SPD2   = 5'd3;
    localparam logic [4:0] ST_SPD3   = 5'd4;
    localparam logic [4:0] ST_SPD4   = 5'd5;
    localparam logic [4:0] ST_ACC1   = 5'd6;
    localparam logic [4:0] ST_ACC2   = 5'd7;
    localparam logic [4:0] ST_ACCW   = 5'd8;
    localparam logic [4:0] ST_SQ0    = 5'd9;
    localparam logic [4:0] ST_SQ1    = 5'd10;
    localparam logic [4:0] ST_SQ2    = 5'd11;
    localparam logic [4:0] ST_SQ3    = 5'd12;
    localparam logic [4:0] ST_MAG    = 5'd13;
    localparam logic [4:0] ST_MAGW   = 5'd14;
    localparam logic [4:0] ST_MEAN   = 5'd15;
    localparam logic [4:0] ST_MEANW  = 5'd16;
    localparam logic [4:0] ST_DEV0   = 5'd17;
    localparam logic [4:0] ST_DEV1   = 5'd18;
    localparam logic [4:0] ST_FRM    = 5'd19;
    localparam logic [4:0] ST_RMSD   = 5'd20;
    localparam logic [4:0] ST_RMSS   = 5'd21;
    localparam logic [4:0] ST_OUT    = 5'd22;

    localparam logic signed [11:0] SR_C  = 12'(SAMPLE_RATE_HZ);
    localparam logic [3:0]         FD_C  = 4'(FRAME_DIVISOR);

    logic [4:0]  state_reg, state_next;
    logic [18:0] circ_reg;

    logic signed [23:0] spin_reg, ax_reg, ay_reg, az_reg;
    logic               acc_v_reg, temp_v_reg;
    logic [15:0]        die_reg;

    logic [22:0]        speed_reg, prev_reg;
    logic signed [23:0] filt_reg;
    logic [23:0]        mean_reg;
    logic [51:0]        sum_reg;
    logic [3:0]         cnt_reg;
    logic [3:0]         fd_reg;
    logic [15:0]        temp_reg;
    logic [21:0]        tl_reg;
    logic [61:0]        acc_reg;
    logic signed [35:0] a_reg;
    logic [24:0]        mag_reg;
    logic [25:0]        dev_reg;
    logic               neg_reg;
    logic [22:0]        rms_reg;

    logic               m_valid_reg;
    logic [87:0]        m_data_reg;

    logic [25:0] mul_a, mul_b;
    logic [51:0] prod;
    logic [24:0] div5_q;
    logic        div_start, div_done;
    logic [51:0] div_num, div_quo;
    logic [4:0]  div_den;
    logic        sq_start, sq_done;
    logic [51:0] sq_val;
    logic [25:0] sq_root;

    logic [23:0]        omega;
    logic [23:0]        abs_x, abs_y, abs_z;
    logic [25:0]        speed_raw;
    logic signed [36:0] n_acc;
    logic signed [28:0] x_acc;
    logic [29:0]        num_acc;
    logic signed [30:0] q_acc, f_sum;
    logic signed [26:0] x_mean;
    logic signed [24:0] xx_mean;
    logic [25:0]        num_mean;
    logic signed [27:0] q_mean, m_sum;
    logic [23:0]        m_new;
    logic signed [26:0] dev_s;
    logic [52:0]        sum_add;
    logic [3:0]         fd_inc;
    logic               frame;
    logic               out_free;

    wsvt_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    wsvt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    wsvt_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .val     (sq_val),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign omega = spin_reg[23] ? 24'(-spin_reg) : 24'(spin_reg);
    assign abs_x = ax_reg[23] ? 24'(-ax_reg) : 24'(ax_reg);
    assign abs_y = ay_reg[23] ? 24'(-ay_reg) : 24'(ay_reg);
    assign abs_z = az_reg[23] ? 24'(-az_reg) : 24'(az_reg);

    assign speed_raw = acc_reg[61:36];

    // floor division by 5 through the reciprocal product
    assign div5_q = prod[51:27];

    assign n_acc   = 37'(a_reg) - {{5{filt_reg[23]}}, filt_reg, 8'b0} + 37'sd640;
    assign x_acc   = n_acc[36:8];
    assign num_acc = x_acc[28] ? 30'(-31'(x_acc) + 31'sd4) : 30'(x_acc);
    assign q_acc   = neg_reg ? -$signed({6'b000000, div5_q}) : $signed({6'b000000, div5_q});
    assign f_sum   = 31'(filt_reg) + q_acc;

    assign x_mean   = $signed({2'b00, mag_reg}) - $signed({3'b000, mean_reg}) + 27'sd10;
    assign xx_mean  = x_mean[26:2];
    assign num_mean = xx_mean[24] ? 26'(-26'(xx_mean) + 26'sd4) : 26'(xx_mean);
    assign q_mean   = neg_reg ? -$signed({3'b000, div5_q})
                              : $signed({3'b000, div5_q});
    assign m_sum    = $signed({4'b0000, mean_reg}) + q_mean;
    assign m_new    = m_sum[27] ? 24'd0 : (m_sum > 28'sd16777215 ? wsvt_pkg::MEAN_MAX
                                                                 : m_sum[23:0]);
    assign dev_s    = $signed({2'b00, mag_reg}) - $signed({3'b000, m_new});

    assign sum_add  = {1'b0, sum_reg} + {1'b0, prod};
    assign fd_inc   = fd_reg + 4'd1;
    assign frame    = fd_inc >= FD_C;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SPD0: begin
                mul_a = 26'(omega);
                mul_b = 26'(circ_reg);
            end
            ST_SPD1: begin
                mul_a = 26'(prod[42:22]);
                mul_b = 26'(wsvt_pkg::INV_TWO_PI_Q20);
            end
            ST_SPD2: begin
                mul_a = 26'(tl_reg);
                mul_b = 26'(wsvt_pkg::INV_TWO_PI_Q20);
            end
            ST_ACC2: begin
                mul_a = 26'(num_acc);
                mul_b = wsvt_pkg::RECIP_5;
            end
            ST_SQ0: begin
                mul_a = 26'(abs_x);
                mul_b = 26'(abs_x);
            end
            ST_SQ1: begin
                mul_a = 26'(abs_y);
                mul_b = 26'(abs_y);
            end
            ST_SQ2: begin
                mul_a = 26'(abs_z);
                mul_b = 26'(abs_z);
            end
            ST_MEAN: begin
                mul_a = num_mean;
                mul_b = wsvt_pkg::RECIP_5;
            end
            ST_DEV0: begin
                mul_a = dev_reg;
                mul_b = dev_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = sum_reg;
        div_den   = {1'b0, cnt_reg};
        sq_start  = 1'b0;
        sq_val    = acc_reg[51:0];
        case (state_reg)
            ST_FRM: begin
                div_start = frame && (cnt_reg != 4'd0);
            end
            ST_MAG: begin
                sq_start = 1'b1;
                sq_val   = acc_reg[51:0];
            end
            ST_RMSD: begin
                sq_start = div_done;
                sq_val   = div_quo;
            end
            default: begin
                div_start = 1'b0;
                sq_start  = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tdata[24] ? ST_SPD0 : ST_ACC1;
                end
            end
            ST_SPD0:  state_next = ST_SPD1;
            ST_SPD1:  state_next = ST_SPD2;
            ST_SPD2:  state_next = ST_SPD3;
            ST_SPD3:  state_next = ST_SPD4;
            ST_SPD4:  state_next = ST_ACC1;
            ST_ACC1:  state_next = ST_ACC2;
            ST_ACC2:  state_next = ST_ACCW;
            ST_ACCW:  state_next = acc_v_reg ? ST_SQ0 : ST_FRM;
            ST_SQ0:   state_next = ST_SQ1;
            ST_SQ1:   state_next = ST_SQ2;
            ST_SQ2:   state_next = ST_SQ3;
            ST_SQ3:   state_next = ST_MAG;
            ST_MAG:   state_next = ST_MAGW;
            ST_MAGW: begin
                if (sq_done) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:  state_next = ST_MEANW;
            ST_MEANW: state_next = ST_DEV0;
            ST_DEV0:  state_next = ST_DEV1;
            ST_DEV1:  state_next = ST_FRM;
            ST_FRM: begin
                if (!frame) begin
                    state_next = ST_IDLE;
                end else if (cnt_reg != 4'd0) begin
                    state_next = ST_RMSD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RMSD: begin
                if (div_done) begin
                    state_next = ST_RMSS;
                end
            end
            ST_RMSS: begin
                if (sq_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            circ_reg    <= wsvt_pkg::CIRC_RESET;
            prev_reg    <= '0;
            filt_reg    <= '0;
            mean_reg    <= '0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            fd_reg      <= '0;
            temp_reg    <= wsvt_pkg::TEMP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                circ_reg <= cfg_wr_data;
            end
            m_valid_reg <= ((state_reg == ST_OUT) && out_free) || (m_valid_reg && !m_tready);
            case (state_reg)
                ST_ACCW: begin
                    if (f_sum > 31'sd8388607) begin
                        filt_reg <= 24'sh7FFFFF;
                    end else if (f_sum < -31'sd8388608) begin
                        filt_reg <= 24'sh800000;
                    end else begin
                        filt_reg <= f_sum[23:0];
                    end
                    prev_reg <= speed_reg;
                end
                ST_MEANW: begin
                    mean_reg <= m_new;
                end
                ST_DEV1: begin
                    sum_reg <= sum_add[52] ? wsvt_pkg::SUM_MAX : sum_add[51:0];
                    if (cnt_reg != 4'd15) begin
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                ST_FRM: begin
                    if (temp_v_reg) begin
                        temp_reg <= die_reg;
                    end
                    fd_reg <= frame ? 4'd0 : fd_inc;
                end
                ST_OUT: begin
                    if (out_free) begin
                        sum_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            spin_reg   <= s_tdata[23:0];
            ax_reg     <= s_tdata[48:25];
            ay_reg     <= s_tdata[72:49];
            az_reg     <= s_tdata[96:73];
            acc_v_reg  <= s_tdata[97];
            die_reg    <= s_tdata[113:98];
            temp_v_reg <= s_tdata[114];
            speed_reg  <= '0;
        end
        case (state_reg)
            ST_SPD1: begin
                tl_reg <= prod[21:0];
            end
            ST_SPD2: begin
                acc_reg <= {prod[39:0], 22'b0};
            end
            ST_SPD3: begin
                acc_reg <= acc_reg + 62'(prod) + (62'd1 << 35);
            end
            ST_SPD4: begin
                if (speed_raw > 26'(wsvt_pkg::SPEED_MAX)) begin
                    speed_reg <= wsvt_pkg::SPEED_MAX;
                end else if (speed_raw[22:0] < wsvt_pkg::SPEED_FLOOR) begin
                    speed_reg <= '0;
                end else begin
                    speed_reg <= speed_raw[22:0];
                end
            end
            ST_ACC1: begin
                a_reg <= 36'(($signed({1'b0, speed_reg}) - $signed({1'b0, prev_reg})) * SR_C);
            end
            ST_ACC2: begin
                neg_reg <= x_acc[28];
            end
            ST_SQ1: begin
                acc_reg <= 62'(prod);
            end
            ST_SQ2, ST_SQ3: begin
                acc_reg <= acc_reg + 62'(prod);
            end
            ST_MAGW: begin
                if (sq_done) begin
                    mag_reg <= sq_root[24:0];
                end
            end
            ST_MEAN: begin
                neg_reg <= xx_mean[24];
            end
            ST_MEANW: begin
                dev_reg <= dev_s[26] ? 26'(-dev_s) : 26'(dev_s);
            end
            ST_FRM: begin
                rms_reg <= '0;
            end
            ST_RMSS: begin
                if (sq_done) begin
                    rms_reg <= (sq_root > 26'(wsvt_pkg::RMS_MAX)) ? wsvt_pkg::RMS_MAX
                                                                  : sq_root[22:0];
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg <= {2'b00, rms_reg, temp_reg, filt_reg, prev_reg};
                end
            end
            default: begin
                neg_reg <= neg_reg;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/wsvt_mul.sv
// ----------------------------------------------------------------------------
// wsvt_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module wsvt_mul (
    input  logic                          aclk,
    input  logic [wsvt_pkg::MUL_W-1:0]    op_a,
    input  logic [wsvt_pkg::MUL_W-1:0]    op_b,
    output logic [2*wsvt_pkg::MUL_W-1:0]  prod
);

    logic [2*wsvt_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: sv/wsvt_div.sv
// ----------------------------------------------------------------------------
// wsvt_div
// restoring divider, one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
module wsvt_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wsvt_pkg::NUM_W-1:0]  num,
    input  logic [wsvt_pkg::DEN_W-1:0]  den,
    output logic                        done,
    output logic [wsvt_pkg::NUM_W-1:0]  quo
);

    logic [wsvt_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [wsvt_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [wsvt_pkg::DEN_W-1:0] den_reg;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [wsvt_pkg::DEN_W:0]   sh;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh        = {rem_reg, quo_reg[wsvt_pkg::NUM_W-1]};
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = 6'(wsvt_pkg::NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next = wsvt_pkg::DEN_W'(sh - {1'b0, den_reg});
                quo_next = {quo_reg[wsvt_pkg::NUM_W-2:0], 1'b1};
            end else begin
                rem_next = sh[wsvt_pkg::DEN_W-1:0];
                quo_next = {quo_reg[wsvt_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: sv/wsvt_sqrt.sv
// ----------------------------------------------------------------------------
// wsvt_sqrt
// digit-by-digit floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module wsvt_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wsvt_pkg::NUM_W-1:0]   val,
    output logic                         done,
    output logic [wsvt_pkg::ROOT_W-1:0]  root
);

    logic [wsvt_pkg::NUM_W-1:0]  v_reg, v_next;
    logic [29:0]                 rem_reg, rem_next;
    logic [wsvt_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [4:0]                  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [29:0]                 r2;
    logic [29:0]                 trial;

    always_comb begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r2        = {rem_reg[27:0], v_reg[wsvt_pkg::NUM_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start) begin
            v_next    = val;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'(wsvt_pkg::ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            v_next = {v_reg[wsvt_pkg::NUM_W-3:0], 2'b00};
            if (r2 >= trial) begin
                rem_next  = r2 - trial;
                root_next = {root_reg[wsvt_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = r2;
                root_next = {root_reg[wsvt_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: sv/wsvt_checker.sv
// ----------------------------------------------------------------------------
// wsvt_checker
// port-level checks of the telemetry unit
// ----------------------------------------------------------------------------
module wsvt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [87:0]  m_tdata
);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not idle after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled frame changed");

endmodule

bind wheel_speed_vibration_telemetry_unit wsvt_checker u_wsvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
